// ===== hw/rtl/fsp_pkg.sv =====
// Shared types, codes and character constants for the format spec parser.
package fsp_pkg;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_FIRST  = 4'd1,
        PH_SECOND = 4'd2,
        PH_ALIGN  = 4'd3,
        PH_SIGN   = 4'd4,
        PH_HASH   = 4'd5,
        PH_ZERO   = 4'd6,
        PH_WIDTH0 = 4'd7,
        PH_WIDTHN = 4'd8,
        PH_COMMA  = 4'd9,
        PH_DOT    = 4'd10,
        PH_PREC0  = 4'd11,
        PH_PRECN  = 4'd12,
        PH_TYPE   = 4'd13,
        PH_DONE   = 4'd14
    } phase_t;

    localparam logic [2:0] ALIGN_NONE   = 3'd0;
    localparam logic [2:0] ALIGN_LEFT   = 3'd1;
    localparam logic [2:0] ALIGN_RIGHT  = 3'd2;
    localparam logic [2:0] ALIGN_SIGN   = 3'd3;
    localparam logic [2:0] ALIGN_CENTER = 3'd4;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;
    localparam logic [1:0] SIGN_SPACE = 2'd3;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_EQUALS     = 3'd1;
    localparam logic [2:0] ERR_SIGN       = 3'd2;
    localparam logic [2:0] ERR_HASH       = 3'd3;
    localparam logic [2:0] ERR_COMMA      = 3'd4;
    localparam logic [2:0] ERR_PREC_INT   = 3'd5;
    localparam logic [2:0] ERR_PREC_EMPTY = 3'd6;

    localparam logic [1:0] CLASS_TEXT    = 2'd0;
    localparam logic [1:0] CLASS_INTEGER = 2'd1;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    localparam int NUM_TYPES = 15;
    localparam logic [7:0] TYPE_LETTERS [NUM_TYPES] = '{
        8'h62, 8'h63, 8'h64, 8'h65, 8'h45, 8'h66, 8'h46, 8'h67,
        8'h47, 8'h6E, 8'h6F, 8'h73, 8'h25, 8'h78, 8'h58
    };

    typedef struct packed {
        logic [7:0] spec_byte;
        logic       is_last;
        logic [1:0] arg_class;
    } spec_word_t;

    typedef struct packed {
        logic        fill_present;
        logic [7:0]  fill_byte;
        logic [2:0]  align_code;
        logic [1:0]  sign_code;
        logic        alt_form;
        logic        zero_pad;
        logic [15:0] field_width;
        logic        grouping;
        logic        has_precision;
        logic [15:0] precision_value;
        logic [7:0]  type_byte;
        logic [2:0]  error_code;
    } result_t;

    function automatic logic [2:0] align_of(logic [7:0] b);
        logic [2:0] a;
        a = ALIGN_NONE;
        if (b == CH_LT) a = ALIGN_LEFT;
        if (b == CH_GT) a = ALIGN_RIGHT;
        if (b == CH_EQ) a = ALIGN_SIGN;
        if (b == CH_CARET) a = ALIGN_CENTER;
        return a;
    endfunction

    function automatic logic [1:0] sign_of(logic [7:0] b);
        logic [1:0] s;
        s = SIGN_NONE;
        if (b == CH_PLUS) s = SIGN_PLUS;
        if (b == CH_MINUS) s = SIGN_MINUS;
        if (b == CH_SPACE) s = SIGN_SPACE;
        return s;
    endfunction

    function automatic logic is_numeral(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_type(logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (TYPE_LETTERS[i] == b) hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

// ===== hw/rtl/fsp_in_stage.sv =====
// Input register: holds one spec word until the parser consumes it.
module fsp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  fsp_pkg::spec_word_t word_in,
    input  logic               consume,
    output logic               full,
    output fsp_pkg::spec_word_t word
);

    logic                full_reg;
    logic                full_next;
    fsp_pkg::spec_word_t word_reg;
    logic                load;

    assign in_stall = full_reg && !consume;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        full_next = full_reg;
        if (load)
        begin
            full_next = 1'b1;
        end
        else if (consume)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word_in;
        end
    end

    assign full = full_reg;
    assign word = word_reg;

endmodule

// ===== hw/rtl/fsp_parse_core.sv =====
// Parser state register and the per-word parse step.
module fsp_parse_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  fsp_pkg::spec_word_t word,
    output fsp_pkg::result_t    result
);

    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

    typedef struct packed {
        fsp_pkg::phase_t phase;
        logic [7:0]      held;
        logic            fill_present;
        logic [7:0]      fill;
        logic [2:0]      align;
        logic [1:0]      sign;
        logic            alt;
        logic            zero;
        logic            grouping;
        logic            prec;
        logic [CB-1:0]   width_acc;
        logic [CB-1:0]   prec_acc;
        logic [7:0]      type_letter;
        logic [2:0]      err;
        logic [1:0]      cls;
    } pstate_t;

    pstate_t state_reg;
    pstate_t state_next;
    pstate_t s;

    function automatic logic [CB-1:0] acc_digit(logic [CB-1:0] acc, logic [7:0] b);
        logic [CB+3:0] w;
        w = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{CB{1'b0}}, b[3:0]};
        return (w > {4'b0000, COUNT_MAX}) ? COUNT_MAX : w[CB-1:0];
    endfunction

    function automatic pstate_t raise_err(pstate_t st, logic [2:0] code);
        pstate_t r;
        r = st;
        if (r.err == fsp_pkg::ERR_NONE) r.err = code;
        r.phase = fsp_pkg::PH_DONE;
        return r;
    endfunction

    // One pass of the phase chain; fin marks that the byte was consumed.
    function automatic pstate_t take(pstate_t st, logic [7:0] b);
        pstate_t    r;
        logic       fin;
        logic       numeric;
        logic [2:0] a;
        logic [1:0] sg;
        r       = st;
        fin     = 1'b0;
        numeric = (st.cls != fsp_pkg::CLASS_TEXT);
        a       = fsp_pkg::align_of(b);
        sg      = fsp_pkg::sign_of(b);
        if (r.phase == fsp_pkg::PH_ALIGN)
        begin
            if (a != fsp_pkg::ALIGN_NONE)
            begin
                fin = 1'b1;
                if (a == fsp_pkg::ALIGN_SIGN && !numeric)
                begin
                    r = raise_err(r, fsp_pkg::ERR_EQUALS);
                end
                else
                begin
                    r.align = a;
                    r.phase = fsp_pkg::PH_SIGN;
                end
            end
            else
            begin
                r.phase = fsp_pkg::PH_SIGN;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_SIGN)
        begin
            if (sg != fsp_pkg::SIGN_NONE)
            begin
                fin = 1'b1;
                if (!numeric)
                begin
                    r = raise_err(r, fsp_pkg::ERR_SIGN);
                end
                else
                begin
                    r.sign  = sg;
                    r.phase = fsp_pkg::PH_HASH;
                end
            end
            else
            begin
                r.phase = fsp_pkg::PH_HASH;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_HASH)
        begin
            if (b == fsp_pkg::CH_HASH)
            begin
                fin = 1'b1;
                if (!numeric)
                begin
                    r = raise_err(r, fsp_pkg::ERR_HASH);
                end
                else
                begin
                    r.alt   = 1'b1;
                    r.phase = fsp_pkg::PH_ZERO;
                end
            end
            else
            begin
                r.phase = fsp_pkg::PH_ZERO;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_ZERO)
        begin
            if (b == fsp_pkg::CH_ZERO)
            begin
                fin = 1'b1;
                if (!r.fill_present)
                begin
                    r.fill_present = 1'b1;
                    r.fill         = fsp_pkg::CH_ZERO;
                end
                if (r.align == fsp_pkg::ALIGN_NONE) r.align = fsp_pkg::ALIGN_SIGN;
                r.zero  = 1'b1;
                r.phase = fsp_pkg::PH_WIDTH0;
            end
            else
            begin
                r.phase = fsp_pkg::PH_WIDTH0;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_WIDTH0)
        begin
            if (fsp_pkg::is_numeral(b))
            begin
                fin = 1'b1;
                if (!r.fill_present)
                begin
                    r.fill_present = 1'b1;
                    r.fill         = fsp_pkg::CH_SPACE;
                end
                r.width_acc = {{(CB-4){1'b0}}, b[3:0]};
                r.phase     = fsp_pkg::PH_WIDTHN;
            end
            else
            begin
                r.phase = fsp_pkg::PH_COMMA;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_WIDTHN)
        begin
            if (fsp_pkg::is_numeral(b))
            begin
                fin         = 1'b1;
                r.width_acc = acc_digit(r.width_acc, b);
            end
            else
            begin
                r.phase = fsp_pkg::PH_COMMA;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_COMMA)
        begin
            if (b == fsp_pkg::CH_COMMA)
            begin
                fin = 1'b1;
                if (!numeric)
                begin
                    r = raise_err(r, fsp_pkg::ERR_COMMA);
                end
                else
                begin
                    r.grouping = 1'b1;
                end
            end
            else
            begin
                r.phase = fsp_pkg::PH_DOT;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_DOT)
        begin
            if (b == fsp_pkg::CH_DOT)
            begin
                fin = 1'b1;
                if (r.cls == fsp_pkg::CLASS_INTEGER)
                begin
                    r = raise_err(r, fsp_pkg::ERR_PREC_INT);
                end
                else
                begin
                    r.prec  = 1'b1;
                    r.phase = fsp_pkg::PH_PREC0;
                end
            end
            else
            begin
                r.phase = fsp_pkg::PH_TYPE;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_PREC0)
        begin
            fin = 1'b1;
            if (fsp_pkg::is_numeral(b))
            begin
                r.prec_acc = {{(CB-4){1'b0}}, b[3:0]};
                r.phase    = fsp_pkg::PH_PRECN;
            end
            else
            begin
                r = raise_err(r, fsp_pkg::ERR_PREC_EMPTY);
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_PRECN)
        begin
            if (fsp_pkg::is_numeral(b))
            begin
                fin        = 1'b1;
                r.prec_acc = acc_digit(r.prec_acc, b);
            end
            else
            begin
                r.phase = fsp_pkg::PH_TYPE;
            end
        end
        if (!fin && r.phase == fsp_pkg::PH_TYPE)
        begin
            if (fsp_pkg::is_type(b)) r.type_letter = b;
            r.phase = fsp_pkg::PH_DONE;
        end
        return r;
    endfunction

    logic [CB+15:0] width_ext;
    logic [CB+15:0] prec_ext;
    logic [2:0]     sec_align;
    logic           held_brace;

    always_comb
    begin
        s          = state_reg;
        sec_align  = fsp_pkg::align_of(word.spec_byte);
        held_brace = (state_reg.held == fsp_pkg::CH_LBRACE)
                  || (state_reg.held == fsp_pkg::CH_RBRACE);
        unique case (state_reg.phase)
            fsp_pkg::PH_START:
            begin
                s.cls   = word.arg_class;
                s.phase = (word.spec_byte == fsp_pkg::CH_COLON) ? fsp_pkg::PH_FIRST
                                                                 : fsp_pkg::PH_DONE;
            end
            fsp_pkg::PH_FIRST:
            begin
                s.held  = word.spec_byte;
                s.phase = fsp_pkg::PH_SECOND;
            end
            fsp_pkg::PH_SECOND:
            begin
                if (sec_align != fsp_pkg::ALIGN_NONE && !held_brace)
                begin
                    if (sec_align == fsp_pkg::ALIGN_SIGN && s.cls == fsp_pkg::CLASS_TEXT)
                    begin
                        s = raise_err(s, fsp_pkg::ERR_EQUALS);
                    end
                    else
                    begin
                        s.fill_present = 1'b1;
                        s.fill         = state_reg.held;
                        s.align        = sec_align;
                        s.phase        = fsp_pkg::PH_SIGN;
                    end
                end
                else
                begin
                    // no fill: replay the held byte, then this one
                    s.phase = (sec_align != fsp_pkg::ALIGN_NONE) ? fsp_pkg::PH_SIGN
                                                                 : fsp_pkg::PH_ALIGN;
                    s = take(s, state_reg.held);
                    s = take(s, word.spec_byte);
                end
            end
            fsp_pkg::PH_DONE:
            begin
                s = state_reg;
            end
            default:
            begin
                s = take(s, word.spec_byte);
            end
        endcase

        if (s.phase == fsp_pkg::PH_SECOND)
        begin
            // spec ends right after the fill candidate
            if (word.is_last)
            begin
                s.phase = fsp_pkg::PH_ALIGN;
                s = take(s, s.held);
            end
        end
        if (word.is_last && s.phase == fsp_pkg::PH_PREC0)
        begin
            s = raise_err(s, fsp_pkg::ERR_PREC_EMPTY);
        end

        state_next = word.is_last ? '0 : s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign width_ext = {16'h0000, s.width_acc};
    assign prec_ext  = {16'h0000, s.prec_acc};

    always_comb
    begin
        result = '0;
        result.error_code = s.err;
        if (s.err == fsp_pkg::ERR_NONE)
        begin
            result.fill_present    = s.fill_present;
            result.fill_byte       = s.fill_present ? s.fill : 8'h00;
            result.align_code      = s.align;
            result.sign_code       = s.sign;
            result.alt_form        = s.alt;
            result.zero_pad        = s.zero;
            result.field_width     = width_ext[15:0];
            result.grouping        = s.grouping;
            result.has_precision   = s.prec;
            result.precision_value = prec_ext[15:0];
            result.type_byte       = s.type_letter;
        end
    end

endmodule

// ===== hw/rtl/fsp_out_stage.sv =====
// Result register with valid/stall handshake toward the consumer.
module fsp_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fsp_pkg::result_t result_in,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_stall,
    output fsp_pkg::result_t result
);

    logic             valid_reg;
    logic             valid_next;
    fsp_pkg::result_t result_reg;

    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// ===== hw/rtl/format_spec_parser_top.sv =====
// Top level of the format spec parser: input register, parse step, result register.
// Parsing: a word is parsed as it leaves the input register, and the result of a
// last word is loaded into the result register, which drives the outputs.
// Throughput: one word per cycle; the input register is freed in the same cycle
// a result is taken, so the stream pauses only while the result register stalls.
// Reset: rst_n clears both valid bits and returns the parser to awaiting ':'.
module format_spec_parser_top #(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  spec_byte,
    input  logic        is_last,
    input  logic [1:0]  arg_class,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        fill_present,
    output logic [7:0]  fill_byte,
    output logic [2:0]  align_code,
    output logic [1:0]  sign_code,
    output logic        alt_form,
    output logic        zero_pad,
    output logic [15:0] field_width,
    output logic        grouping,
    output logic        has_precision,
    output logic [15:0] precision_value,
    output logic [7:0]  type_byte,
    output logic [2:0]  error_code
);

    fsp_pkg::spec_word_t word_in;
    fsp_pkg::spec_word_t word;
    fsp_pkg::result_t    parse_result;
    fsp_pkg::result_t    result;
    logic                full;
    logic                fire;
    logic                can_load;
    logic                load;

    assign word_in.spec_byte = spec_byte;
    assign word_in.is_last   = is_last;
    assign word_in.arg_class = arg_class;

    // a last word advances only when the result register has room
    assign fire = full && (!word.is_last || can_load);
    assign load = fire && word.is_last;

    fsp_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .word_in (word_in),
        .consume (fire),
        .full    (full),
        .word    (word)
    );

    fsp_parse_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .word  (word),
        .result(parse_result)
    );

    fsp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result_in(parse_result),
        .can_load (can_load),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result   (result)
    );

    assign fill_present    = result.fill_present;
    assign fill_byte       = result.fill_byte;
    assign align_code      = result.align_code;
    assign sign_code       = result.sign_code;
    assign alt_form        = result.alt_form;
    assign zero_pad        = result.zero_pad;
    assign field_width     = result.field_width;
    assign grouping        = result.grouping;
    assign has_precision   = result.has_precision;
    assign precision_value = result.precision_value;
    assign type_byte       = result.type_byte;
    assign error_code      = result.error_code;

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> full)
        else $error("input stalled with empty input register");

    a_last_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("consumed last word did not produce a result");

    a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error_code != fsp_pkg::ERR_NONE) |->
            (field_width == 16'h0000 && type_byte == 8'h00 && !fill_present))
        else $error("error result carries nonzero fields");

    a_align_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (align_code <= fsp_pkg::ALIGN_CENTER
                       && error_code <= fsp_pkg::ERR_PREC_EMPTY))
        else $error("result code out of range");

endmodule

// ===== dv/format_spec_parser_top_tb.sv =====
// Self-checking testbench for the format spec parser: directed specs, then random specs.
module format_spec_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]  CLASS_FLOAT = 2'd2;
    localparam logic [1:0]  CLASS_OTHER = 2'd3;
    localparam logic [31:0] COUNT_MAX   = 32'd65535;
    localparam int          STALL_LIMIT = 4000;
    localparam int          HOLD_LEN    = 300;
    localparam int          PHASE_WORDS = 260;
    localparam string       TYPE_SET    = "bcdeEfFgGnos%xX";
    localparam string       ALIGN_CHARS = "<>=^";
    localparam string       SIGN_CHARS  = "+- ";
    localparam string       DIGITS      = "0123456789";
    localparam int          IDLE_PLAN  [4] = '{0, 72, 0, 33};
    localparam int          STALL_PLAN [4] = '{0, 0, 72, 33};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  spec_byte;
    logic        is_last;
    logic [1:0]  arg_class;
    logic        out_valid;
    logic        out_stall;
    logic        fill_present;
    logic [7:0]  fill_byte;
    logic [2:0]  align_code;
    logic [1:0]  sign_code;
    logic        alt_form;
    logic        zero_pad;
    logic [15:0] field_width;
    logic        grouping;
    logic        has_precision;
    logic [15:0] precision_value;
    logic [7:0]  type_byte;
    logic [2:0]  error_code;

    format_spec_parser_top dut (.*);

    always #4 clk = ~clk;

    // Parser shadow state
    fsp_pkg::phase_t ph;
    logic [7:0]  held;
    bit          held_ok;
    bit          fill_on;
    logic [7:0]  fill_ch;
    logic [2:0]  al;
    logic [1:0]  sg;
    bit          alt;
    bit          zpad;
    bit          grp;
    bit          prec_on;
    logic [31:0] wid;
    logic [31:0] prc;
    logic [7:0]  ty;
    logic [2:0]  err;
    logic [1:0]  cls;

    fsp_pkg::result_t spec_results_due[$];
    logic [7:0]  spec_bytes[$];
    int          mismatches = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;

    typedef struct {
        string            text;
        logic [1:0]       cls;
        int               nul_pos;
        bit               typed;
        fsp_pkg::result_t want;
    } spec_row_t;

    spec_row_t directed_rows [25] = '{
        '{":",            fsp_pkg::CLASS_TEXT,    -1, 1'b1, '0},
        '{"x",            CLASS_FLOAT,            -1, 1'b1, '0},
        '{":=",           fsp_pkg::CLASS_TEXT,    -1, 1'b1,
          '{error_code: fsp_pkg::ERR_EQUALS, default: '0}},
        '{":x=",          fsp_pkg::CLASS_TEXT,    -1, 1'b1,
          '{error_code: fsp_pkg::ERR_EQUALS, default: '0}},
        '{":+",           fsp_pkg::CLASS_TEXT,    -1, 1'b1,
          '{error_code: fsp_pkg::ERR_SIGN, default: '0}},
        '{":#",           fsp_pkg::CLASS_TEXT,    -1, 1'b1,
          '{error_code: fsp_pkg::ERR_HASH, default: '0}},
        '{":,",           fsp_pkg::CLASS_TEXT,    -1, 1'b1,
          '{error_code: fsp_pkg::ERR_COMMA, default: '0}},
        '{":.5",          fsp_pkg::CLASS_INTEGER, -1, 1'b1,
          '{error_code: fsp_pkg::ERR_PREC_INT, default: '0}},
        '{":.",           CLASS_FLOAT,            -1, 1'b1,
          '{error_code: fsp_pkg::ERR_PREC_EMPTY, default: '0}},
        '{":.x",          CLASS_FLOAT,            -1, 1'b1,
          '{error_code: fsp_pkg::ERR_PREC_EMPTY, default: '0}},
        '{":{<5",         CLASS_FLOAT,            -1, 1'b1, '0},
        '{":}>",          fsp_pkg::CLASS_INTEGER, -1, 1'b1, '0},
        '{":0",           fsp_pkg::CLASS_TEXT,    -1, 1'b1,
          '{fill_present: 1'b1, fill_byte: fsp_pkg::CH_ZERO,
            align_code: fsp_pkg::ALIGN_SIGN, zero_pad: 1'b1, default: '0}},
        '{":99999999",    fsp_pkg::CLASS_INTEGER, -1, 1'b1,
          '{fill_present: 1'b1, fill_byte: fsp_pkg::CH_SPACE,
            field_width: 16'hFFFF, default: '0}},
        '{":.99999999",   CLASS_FLOAT,            -1, 1'b1,
          '{has_precision: 1'b1, precision_value: 16'hFFFF, default: '0}},
        '{":?",           CLASS_FLOAT,             1, 1'b1, '0},
        '{":?<",          fsp_pkg::CLASS_TEXT,     1, 1'b1,
          '{fill_present: 1'b1, align_code: fsp_pkg::ALIGN_LEFT, default: '0}},
        '{":\377>-#,.0X", CLASS_OTHER,            -1, 1'b0, '0},
        '{":<d~~~",       fsp_pkg::CLASS_INTEGER, -1, 1'b0, '0},
        '{":,,,g",        CLASS_FLOAT,            -1, 1'b0, '0},
        '{": 5",          fsp_pkg::CLASS_INTEGER, -1, 1'b0, '0},
        '{":x^ 07,,.12%", CLASS_FLOAT,            -1, 1'b0, '0},
        '{":s",           fsp_pkg::CLASS_TEXT,    -1, 1'b0, '0},
        '{":*=+#0123,.456e", CLASS_FLOAT,         -1, 1'b0, '0},
        '{":65535b",      fsp_pkg::CLASS_INTEGER, -1, 1'b0, '0}
    };

    function automatic logic [2:0] align_code_of(logic [7:0] b);
        unique case (b)
            fsp_pkg::CH_LT:    return fsp_pkg::ALIGN_LEFT;
            fsp_pkg::CH_GT:    return fsp_pkg::ALIGN_RIGHT;
            fsp_pkg::CH_EQ:    return fsp_pkg::ALIGN_SIGN;
            fsp_pkg::CH_CARET: return fsp_pkg::ALIGN_CENTER;
            default:           return fsp_pkg::ALIGN_NONE;
        endcase
    endfunction

    function automatic logic [1:0] sign_code_of(logic [7:0] b);
        unique case (b)
            fsp_pkg::CH_PLUS:  return fsp_pkg::SIGN_PLUS;
            fsp_pkg::CH_MINUS: return fsp_pkg::SIGN_MINUS;
            fsp_pkg::CH_SPACE: return fsp_pkg::SIGN_SPACE;
            default:           return fsp_pkg::SIGN_NONE;
        endcase
    endfunction

    function automatic bit digit(logic [7:0] b);
        return (b >= fsp_pkg::CH_ZERO) && (b <= fsp_pkg::CH_NINE);
    endfunction

    function automatic bit type_letter(logic [7:0] b);
        for (int k = 0; k < TYPE_SET.len(); k++)
        begin
            if (TYPE_SET[k] == b) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] push_digit(logic [31:0] acc, logic [7:0] b);
        logic [31:0] v;
        v = acc * 10 + 32'(b - fsp_pkg::CH_ZERO);
        return (v > COUNT_MAX) ? COUNT_MAX : v;
    endfunction

    function automatic void clear_parser();
        ph = fsp_pkg::PH_START;
        held = 8'h00;
        held_ok = 1'b0;
        fill_on = 1'b0;
        fill_ch = 8'h00;
        al = fsp_pkg::ALIGN_NONE;
        sg = fsp_pkg::SIGN_NONE;
        alt = 1'b0;
        zpad = 1'b0;
        grp = 1'b0;
        prec_on = 1'b0;
        wid = '0;
        prc = '0;
        ty = 8'h00;
        err = fsp_pkg::ERR_NONE;
        cls = fsp_pkg::CLASS_TEXT;
    endfunction

    // Latch the first error only; stop parsing either way.
    function automatic void fail_parse(logic [2:0] code);
        if (err == fsp_pkg::ERR_NONE) err = code;
        ph = fsp_pkg::PH_DONE;
    endfunction

    // Walk one byte through the field order, falling through absent fields.
    function automatic void absorb_byte(logic [7:0] b);
        logic [2:0] a;
        logic [1:0] s;
        a = align_code_of(b);
        s = sign_code_of(b);
        if (ph == fsp_pkg::PH_ALIGN)
        begin
            if (a != fsp_pkg::ALIGN_NONE)
            begin
                if (a == fsp_pkg::ALIGN_SIGN && cls == fsp_pkg::CLASS_TEXT)
                begin
                    fail_parse(fsp_pkg::ERR_EQUALS);
                    return;
                end
                al = a;
                ph = fsp_pkg::PH_SIGN;
                return;
            end
            ph = fsp_pkg::PH_SIGN;
        end
        if (ph == fsp_pkg::PH_SIGN)
        begin
            if (s != fsp_pkg::SIGN_NONE)
            begin
                if (cls == fsp_pkg::CLASS_TEXT)
                begin
                    fail_parse(fsp_pkg::ERR_SIGN);
                    return;
                end
                sg = s;
                ph = fsp_pkg::PH_HASH;
                return;
            end
            ph = fsp_pkg::PH_HASH;
        end
        if (ph == fsp_pkg::PH_HASH)
        begin
            if (b == fsp_pkg::CH_HASH)
            begin
                if (cls == fsp_pkg::CLASS_TEXT)
                begin
                    fail_parse(fsp_pkg::ERR_HASH);
                    return;
                end
                alt = 1'b1;
                ph = fsp_pkg::PH_ZERO;
                return;
            end
            ph = fsp_pkg::PH_ZERO;
        end
        if (ph == fsp_pkg::PH_ZERO)
        begin
            if (b == fsp_pkg::CH_ZERO)
            begin
                if (!fill_on)
                begin
                    fill_on = 1'b1;
                    fill_ch = fsp_pkg::CH_ZERO;
                end
                if (al == fsp_pkg::ALIGN_NONE) al = fsp_pkg::ALIGN_SIGN;
                zpad = 1'b1;
                ph = fsp_pkg::PH_WIDTH0;
                return;
            end
            ph = fsp_pkg::PH_WIDTH0;
        end
        if (ph == fsp_pkg::PH_WIDTH0)
        begin
            if (digit(b))
            begin
                if (!fill_on)
                begin
                    fill_on = 1'b1;
                    fill_ch = fsp_pkg::CH_SPACE;
                end
                wid = 32'(b - fsp_pkg::CH_ZERO);
                ph = fsp_pkg::PH_WIDTHN;
                return;
            end
            ph = fsp_pkg::PH_COMMA;
        end
        if (ph == fsp_pkg::PH_WIDTHN)
        begin
            if (digit(b))
            begin
                wid = push_digit(wid, b);
                return;
            end
            ph = fsp_pkg::PH_COMMA;
        end
        if (ph == fsp_pkg::PH_COMMA)
        begin
            if (b == fsp_pkg::CH_COMMA)
            begin
                if (cls == fsp_pkg::CLASS_TEXT)
                begin
                    fail_parse(fsp_pkg::ERR_COMMA);
                    return;
                end
                grp = 1'b1;
                return;
            end
            ph = fsp_pkg::PH_DOT;
        end
        if (ph == fsp_pkg::PH_DOT)
        begin
            if (b == fsp_pkg::CH_DOT)
            begin
                if (cls == fsp_pkg::CLASS_INTEGER)
                begin
                    fail_parse(fsp_pkg::ERR_PREC_INT);
                    return;
                end
                prec_on = 1'b1;
                ph = fsp_pkg::PH_PREC0;
                return;
            end
            ph = fsp_pkg::PH_TYPE;
        end
        if (ph == fsp_pkg::PH_PREC0)
        begin
            if (digit(b))
            begin
                prc = 32'(b - fsp_pkg::CH_ZERO);
                ph = fsp_pkg::PH_PRECN;
                return;
            end
            fail_parse(fsp_pkg::ERR_PREC_EMPTY);
            return;
        end
        if (ph == fsp_pkg::PH_PRECN)
        begin
            if (digit(b))
            begin
                prc = push_digit(prc, b);
                return;
            end
            ph = fsp_pkg::PH_TYPE;
        end
        if (ph == fsp_pkg::PH_TYPE)
        begin
            if (type_letter(b)) ty = b;
            ph = fsp_pkg::PH_DONE;
        end
    endfunction

    // Advance the shadow parser by one word; return 1 with the result on a last word.
    function automatic bit parse_word(logic [7:0] b, bit last, logic [1:0] c,
                                      output fsp_pkg::result_t r);
        logic [2:0] a;
        logic [7:0] c0;
        r = '0;
        if (ph == fsp_pkg::PH_START)
        begin
            cls = c;
            ph = (b == fsp_pkg::CH_COLON) ? fsp_pkg::PH_FIRST : fsp_pkg::PH_DONE;
        end
        else if (ph == fsp_pkg::PH_FIRST)
        begin
            held = b;
            held_ok = 1'b1;
            ph = fsp_pkg::PH_SECOND;
        end
        else if (ph == fsp_pkg::PH_SECOND)
        begin
            a = align_code_of(b);
            c0 = held;
            held_ok = 1'b0;
            if (a != fsp_pkg::ALIGN_NONE && c0 != fsp_pkg::CH_LBRACE
                && c0 != fsp_pkg::CH_RBRACE)
            begin
                if (a == fsp_pkg::ALIGN_SIGN && cls == fsp_pkg::CLASS_TEXT)
                begin
                    fail_parse(fsp_pkg::ERR_EQUALS);
                end
                else
                begin
                    fill_on = 1'b1;
                    fill_ch = c0;
                    al = a;
                    ph = fsp_pkg::PH_SIGN;
                end
            end
            else
            begin
                // a brace never acts as fill, so skip the align slot for it
                ph = (a != fsp_pkg::ALIGN_NONE) ? fsp_pkg::PH_SIGN : fsp_pkg::PH_ALIGN;
                absorb_byte(c0);
                absorb_byte(b);
            end
        end
        else if (ph != fsp_pkg::PH_DONE)
        begin
            absorb_byte(b);
        end
        if (!last) return 1'b0;
        if (ph == fsp_pkg::PH_SECOND && held_ok)
        begin
            held_ok = 1'b0;
            ph = fsp_pkg::PH_ALIGN;
            absorb_byte(held);
        end
        if (ph == fsp_pkg::PH_PREC0) fail_parse(fsp_pkg::ERR_PREC_EMPTY);
        if (err != fsp_pkg::ERR_NONE)
        begin
            r.error_code = err;
        end
        else
        begin
            r.fill_present = fill_on;
            r.fill_byte = fill_on ? fill_ch : 8'h00;
            r.align_code = al;
            r.sign_code = sg;
            r.alt_form = alt;
            r.zero_pad = zpad;
            r.field_width = wid[15:0];
            r.grouping = grp;
            r.has_precision = prec_on;
            r.precision_value = prc[15:0];
            r.type_byte = ty;
            r.error_code = fsp_pkg::ERR_NONE;
        end
        clear_parser();
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic void append_byte(logic [7:0] b);
        spec_bytes.insert(spec_bytes.size(), b);
    endfunction

    function automatic void push_digits(int n);
        for (int k = 0; k < n; k++) append_byte(pick_char(DIGITS));
    endfunction

    // Build one spec into spec_bytes: mostly well-formed, some noise and truncation.
    function automatic logic [1:0] make_spec();
        int n;
        int k;
        spec_bytes.delete();
        if ($urandom_range(99) < 12)
        begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++)
            begin
                if (k == 0 && $urandom_range(1) == 1) append_byte(fsp_pkg::CH_COLON);
                else append_byte(8'($urandom_range(255)));
            end
            return 2'($urandom_range(3));
        end
        append_byte(fsp_pkg::CH_COLON);
        case ($urandom_range(3))
            1: append_byte(pick_char(ALIGN_CHARS));
            2:
            begin
                if ($urandom_range(9) == 0) append_byte(pick_char("{}"));
                else append_byte(8'($urandom_range(255)));
                append_byte(pick_char(ALIGN_CHARS));
            end
            default: ;
        endcase
        if ($urandom_range(99) < 40) append_byte(pick_char(SIGN_CHARS));
        if ($urandom_range(99) < 30) append_byte(fsp_pkg::CH_HASH);
        if ($urandom_range(99) < 30) append_byte(fsp_pkg::CH_ZERO);
        if ($urandom_range(99) < 50)
            push_digits(($urandom_range(99) < 8) ? $urandom_range(5, 7) : $urandom_range(1, 3));
        if ($urandom_range(99) < 20)
        begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) append_byte(fsp_pkg::CH_COMMA);
        end
        if ($urandom_range(99) < 40)
        begin
            append_byte(fsp_pkg::CH_DOT);
            if ($urandom_range(99) >= 8)
                push_digits(($urandom_range(99) < 8) ? $urandom_range(5, 7)
                                                    : $urandom_range(1, 3));
        end
        k = $urandom_range(99);
        if (k < 60) append_byte(pick_char(TYPE_SET));
        else if (k < 70) append_byte(8'($urandom_range(255)));
        if ($urandom_range(99) < 10)
        begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) append_byte(8'($urandom_range(255)));
        end
        // cut short to end on the lookahead byte, a dot, or mid number
        if ($urandom_range(99) < 15)
        begin
            n = $urandom_range(1, spec_bytes.size());
            while (spec_bytes.size() > n) void'(spec_bytes.pop_back());
        end
        return 2'($urandom_range(3));
    endfunction

    task automatic send_word(logic [7:0] b, bit last, logic [1:0] c,
                             output bit made, output fsp_pkg::result_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        spec_byte <= b;
        is_last <= last;
        arg_class <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        made = parse_word(b, last, c, r);
    endtask

    task automatic send_spec(logic [1:0] c, bit typed, fsp_pkg::result_t want);
        bit made;
        fsp_pkg::result_t r;
        for (int i = 0; i < spec_bytes.size(); i++)
        begin
            send_word(spec_bytes[i], i == spec_bytes.size() - 1,
                      (i == 0) ? c : 2'($urandom_range(3)), made, r);
            if (made) spec_results_due.insert(spec_results_due.size(), typed ? want : r);
        end
    endtask

    // Hold the sender until every parsed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (spec_results_due.size() != 0);
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_result();
        fsp_pkg::result_t w;
        if (spec_results_due.size() == 0)
        begin
            $error("result word with nothing expected");
            mismatches++;
            return;
        end
        w = spec_results_due.pop_front();
        check_field("fill_present", 32'(w.fill_present), 32'(fill_present));
        check_field("fill_byte", 32'(w.fill_byte), 32'(fill_byte));
        check_field("align_code", 32'(w.align_code), 32'(align_code));
        check_field("sign_code", 32'(w.sign_code), 32'(sign_code));
        check_field("alt_form", 32'(w.alt_form), 32'(alt_form));
        check_field("zero_pad", 32'(w.zero_pad), 32'(zero_pad));
        check_field("field_width", 32'(w.field_width), 32'(field_width));
        check_field("grouping", 32'(w.grouping), 32'(grouping));
        check_field("has_precision", 32'(w.has_precision), 32'(has_precision));
        check_field("precision_value", 32'(w.precision_value), 32'(precision_value));
        check_field("type_byte", 32'(w.type_byte), 32'(type_byte));
        check_field("error_code", 32'(w.error_code), 32'(error_code));
    endfunction

    // Result side: check accepted words, stall at random or for a requested hold.
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall) check_result();
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_LEN;
            end
            out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int sent;
        bit held_off;
        logic [1:0] c;
        rst_n = 1'b0;
        in_valid = 1'b0;
        spec_byte = 8'h00;
        is_last = 1'b0;
        arg_class = fsp_pkg::CLASS_TEXT;
        held_off = 1'b0;
        clear_parser();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            spec_bytes.delete();
            for (int i = 0; i < directed_rows[r].text.len(); i++)
                append_byte((i == directed_rows[r].nul_pos) ? 8'h00
                                                            : directed_rows[r].text[i]);
            send_spec(directed_rows[r].cls, directed_rows[r].typed, directed_rows[r].want);
        end
        drain_results();

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = IDLE_PLAN[p];
            stall_pct = STALL_PLAN[p];
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                // long receiver hold while the sender keeps offering back to back
                if (p == 0 && !held_off && sent > 100)
                begin
                    held_off = 1'b1;
                    hold_requests++;
                end
                c = make_spec();
                sent += spec_bytes.size();
                send_spec(c, 1'b0, '0);
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && spec_results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_in_stage.sv
hw/rtl/fsp_parse_core.sv
hw/rtl/fsp_out_stage.sv
hw/rtl/format_spec_parser_top.sv
dv/format_spec_parser_top_tb.sv
